FILE: sv/sprite_sheet_frame_uv_unit_macros.svh
// Assertion macros shared by the sprite sheet frame/uv RTL.
// Each check is clocked on the rising edge and held off while reset is low.
`ifndef SPRITE_SHEET_FRAME_UV_UNIT_MACROS_SVH
`define SPRITE_SHEET_FRAME_UV_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define SSFUV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define SSFUV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SSFUV_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SSFUV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/ssfuv_pkg.sv
`default_nettype none

package ssfuv_pkg;

    localparam int FRAME_W   = 12;
    localparam int SIDE_W    = 7;
    localparam int LEN_W     = 16;
    localparam int DELTA_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 13;
    localparam int ANIM_W    = 29;
    localparam int AREA_W    = 14;
    localparam int NUM_W     = 13;
    localparam int QUO_W     = 12;
    localparam int SIDE_CMP_W = 9;

    localparam int MAX_SIDE          = 64;
    localparam int TIME_BITS_DEF     = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [FRAME_W-1:0] FRAME_MAX = 12'hFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHEET_COLUMNS = 3'd0,
        REG_SHEET_ROWS    = 3'd1,
        REG_FIRST_FRAME   = 3'd2,
        REG_LAST_FRAME    = 3'd3,
        REG_FRAME_LENGTH  = 3'd4
    } ssfuv_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_WRAP,
        S_TDIV,
        S_FRAME,
        S_RDIV,
        S_ELOAD,
        S_EDGE,
        S_DONE
    } ssfuv_state_t;

    typedef struct packed {
        logic in_ready;
        logic prep_en;
        logic wrap_en;
        logic tdiv_step;
        logic frame_en;
        logic rdiv_step;
        logic edge_start;
        logic edge_step;
        logic out_load;
    } ssfuv_ctrl_t;

    // Zero side counts as one, anything above the limit is pinned to it.
    function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (SIDE_CMP_W'(v) > SIDE_CMP_W'(MAX_SIDE))
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ssfuv_serial_div.sv
`default_nettype none

// Restoring divider, one quotient bit per step; dividend must be below divisor << Q_W.
module ssfuv_serial_div import ssfuv_pkg::*; #(
    parameter int N_W = 12,
    parameter int D_W = 7,
    parameter int Q_W = 12
) (
    input  wire logic           clk,
    input  wire logic           start,
    input  wire logic           step,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic      [Q_W-1:0] quotient,
    output logic      [N_W-1:0] remainder
);

    localparam int SH_W = D_W + Q_W - 1;
    localparam int CW   = (N_W > SH_W) ? N_W : SH_W;

    logic [N_W-1:0]  rem_reg, rem_next;
    logic [SH_W-1:0] dsr_reg, dsr_next;
    logic [Q_W-1:0]  q_reg, q_next;
    logic [CW-1:0]   rem_ext, dsr_ext, diff;
    logic            fits;

    always_comb
    begin
        rem_ext  = CW'(rem_reg);
        dsr_ext  = CW'(dsr_reg);
        fits     = (rem_ext >= dsr_ext);
        diff     = rem_ext - dsr_ext;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        q_next   = q_reg;
        if (start)
        begin
            rem_next = dividend;
            dsr_next = SH_W'(divisor) << (Q_W - 1);
            q_next   = '0;
        end
        else if (step)
        begin
            rem_next = fits ? N_W'(diff) : rem_reg;
            dsr_next = dsr_reg >> 1;
            q_next   = {q_reg[Q_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: sv/ssfuv_edge_lane.sv
`default_nettype none

// Fraction lane: floor(num * 2^FRAC_W / den), pinned to 2^FRAC_W when num >= den.
module ssfuv_edge_lane import ssfuv_pkg::*; #(
    parameter int FRAC_W = FRACTION_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              start,
    input  wire logic              step,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [SIDE_W-1:0] den,
    output logic      [FRAC_W:0]   edge_val
);

    logic              sat_reg, sat_next;
    logic [SIDE_W-1:0] rem_reg, rem_next;
    logic [FRAC_W-1:0] q_reg, q_next;
    logic [SIDE_W:0]   shifted, den_ext, diff;
    logic              fits;

    always_comb
    begin
        shifted  = {rem_reg, 1'b0};
        den_ext  = {1'b0, den};
        fits     = (shifted >= den_ext);
        diff     = shifted - den_ext;
        sat_next = sat_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        if (start)
        begin
            sat_next = (num >= NUM_W'(den));
            rem_next = (num >= NUM_W'(den)) ? '0 : num[SIDE_W-1:0];
            q_next   = '0;
        end
        else if (step)
        begin
            // shift in one bit of the fraction
            rem_next = fits ? diff[SIDE_W-1:0] : shifted[SIDE_W-1:0];
            q_next   = {q_reg[FRAC_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign edge_val = sat_reg ? {1'b1, {FRAC_W{1'b0}}} : {1'b0, q_reg};

endmodule

`default_nettype wire

FILE: sv/ssfuv_ctrl.sv
`default_nettype none

`include "sprite_sheet_frame_uv_unit_macros.svh"

module ssfuv_ctrl import ssfuv_pkg::*; #(
    parameter int CNT_W  = 4,
    parameter int FRAC_W = FRACTION_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  out_free,
    output ssfuv_ctrl_t ctl
);

    localparam logic [CNT_W-1:0] QUO_LAST  = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FRAC_W - 1);

    ssfuv_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             quo_done, frac_done;

    assign quo_done  = (cnt_reg == QUO_LAST);
    assign frac_done = (cnt_reg == FRAC_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PREP;
            S_PREP:  state_next = S_WRAP;
            S_WRAP:  state_next = S_TDIV;
            S_TDIV:  if (quo_done) state_next = S_FRAME;
            S_FRAME: state_next = S_RDIV;
            S_RDIV:  if (quo_done) state_next = S_ELOAD;
            S_ELOAD: state_next = S_EDGE;
            S_EDGE:  if (frac_done) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            S_IDLE:  ctl.in_ready   = 1'b1;
            S_PREP:  ctl.prep_en    = 1'b1;
            S_WRAP:  ctl.wrap_en    = 1'b1;
            S_TDIV:  ctl.tdiv_step  = 1'b1;
            S_FRAME: ctl.frame_en   = 1'b1;
            S_RDIV:  ctl.rdiv_step  = 1'b1;
            S_ELOAD: ctl.edge_start = 1'b1;
            S_EDGE:  ctl.edge_step  = 1'b1;
            S_DONE:  ctl.out_load   = out_free;
            default: ctl = '0;
        endcase
    end

    // Step counter runs only in the iterating states and parks at zero otherwise.
    always_comb
    begin
        cnt_next = '0;
        if (((state_reg == S_TDIV) || (state_reg == S_RDIV)) && !quo_done)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if ((state_reg == S_EDGE) && !frac_done)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `SSFUV_ASSERT_NEXT(a_take_then_prep, clk, rst_n, in_valid && ctl.in_ready, ctl.prep_en)
    `SSFUV_ASSERT_NEXT(a_tdiv_then_frame, clk, rst_n, (state_reg == S_TDIV) && quo_done, ctl.frame_en)
    `SSFUV_ASSERT_IMP(a_load_when_free, clk, rst_n, ctl.out_load, out_free && (state_reg == S_DONE))

endmodule

`default_nettype wire

FILE: sv/sprite_sheet_frame_uv_unit.sv
`default_nettype none

`include "sprite_sheet_frame_uv_unit_macros.svh"

// Sprite sheet animation frame selector. Each time_delta word yields one result word:
// the elapsed-time counter is first wrapped to zero once it reaches
// (last_frame - first_frame + 1) * frame_length, the frame is
// first_frame + elapsed / frame_length (saturated at 4095), it is split into row and
// column of the sheet, and the four texture edges come out as unsigned fixed point with
// FRACTION_BITS fraction bits, each pinned to 1.0; outside_sheet flags a frame past
// rows * columns. The delta is added to the counter (saturating) after the frame is taken.
// Each word passes through two bit-serial 12-step restoring dividers, one for
// elapsed / frame_length and one for frame / columns, run back to back, followed by four
// parallel fraction lanes, FRACTION_BITS wide (16 by default), that produce one edge
// bit per cycle. The control returns to idle as the result is loaded. A new word is
// taken as soon as the previous result sits in the output register, even if it has not
// been read yet. Registers are to be written only while no word is in flight; the
// block itself does not enforce this.
module sprite_sheet_frame_uv_unit import ssfuv_pkg::*; #(
    parameter int TIME_BITS     = TIME_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [DELTA_W-1:0]       time_delta,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic      [FRAME_W-1:0]       frame_number,
    output logic      [FRACTION_BITS:0]   u_left,
    output logic      [FRACTION_BITS:0]   v_top,
    output logic      [FRACTION_BITS:0]   u_right,
    output logic      [FRACTION_BITS:0]   v_bottom,
    output logic                          outside_sheet
);

    localparam int CMP_W    = (TIME_BITS > ANIM_W) ? TIME_BITS : ANIM_W;
    localparam int EDGE_W   = FRACTION_BITS + 1;
    localparam int STEP_MAX = (FRACTION_BITS > QUO_W) ? FRACTION_BITS : QUO_W;
    localparam int CNT_W    = $clog2(STEP_MAX);
    localparam logic [EDGE_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // Configuration registers
    logic [SIDE_W-1:0]  columns_reg, rows_reg;
    logic [FRAME_W-1:0] first_reg, last_reg;
    logic [LEN_W-1:0]   flen_reg;

    // Working registers
    logic [DELTA_W-1:0]   delta_reg;
    logic [ANIM_W-1:0]    anim_len_reg;
    logic [AREA_W-1:0]    area_reg;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [FRAME_W-1:0]   frame_reg;
    logic                 out_valid_reg;

    // Result registers
    logic [FRAME_W-1:0] frame_out_reg;
    logic [EDGE_W-1:0]  u_left_reg, v_top_reg, u_right_reg, v_bottom_reg;
    logic               outside_reg;

    ssfuv_ctrl_t        c;
    logic [SIDE_W-1:0]  cols, rows;
    logic [LEN_W-1:0]   flen;
    logic [COUNT_W-1:0] count;
    logic               wrap_ge;
    logic [TIME_BITS-1:0] wrapped;
    logic [TIME_BITS:0]   acc_sum;
    logic [QUO_W-1:0]   tdiv_q, rdiv_q;
    logic [FRAME_W-1:0] rdiv_rem;
    logic [FRAME_W:0]   frame_sum;
    logic [FRAME_W-1:0] frame_sat;
    logic [NUM_W-1:0]   col_num, row_num;
    logic [EDGE_W-1:0]  u_left_w, v_top_w, u_right_w, v_bottom_w;
    logic               out_free;

    // Effective register values: clamp sides, treat zero length as one,
    // a reversed interval as a single frame.
    always_comb
    begin
        cols  = side_of(columns_reg);
        rows  = side_of(rows_reg);
        flen  = (flen_reg == '0) ? LEN_W'(1) : flen_reg;
        count = (last_reg >= first_reg)
              ? ({1'b0, last_reg} - {1'b0, first_reg} + COUNT_W'(1))
              : COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= SIDE_W'(1);
            rows_reg    <= SIDE_W'(1);
            first_reg   <= '0;
            last_reg    <= '0;
            flen_reg    <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (ssfuv_reg_t'(cfg_index))
                REG_SHEET_COLUMNS: columns_reg <= cfg_data[SIDE_W-1:0];
                REG_SHEET_ROWS:    rows_reg    <= cfg_data[SIDE_W-1:0];
                REG_FIRST_FRAME:   first_reg   <= cfg_data[FRAME_W-1:0];
                REG_LAST_FRAME:    last_reg    <= cfg_data[FRAME_W-1:0];
                REG_FRAME_LENGTH:  flen_reg    <= cfg_data[LEN_W-1:0];
                default:           ; // drop writes to unused indexes
            endcase
        end
    end

    // Wrap the counter at the animation length, then add the delta with saturation.
    always_comb
    begin
        wrap_ge      = (CMP_W'(elapsed_reg) >= CMP_W'(anim_len_reg));
        wrapped      = wrap_ge ? '0 : elapsed_reg;
        acc_sum      = {1'b0, wrapped} + (TIME_BITS + 1)'(delta_reg);
        elapsed_next = acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];
    end

    // Frame index: interval start plus whole frames elapsed, held at the top index.
    always_comb
    begin
        frame_sum = {1'b0, first_reg} + {1'b0, tdiv_q};
        frame_sat = frame_sum[FRAME_W] ? FRAME_MAX : frame_sum[FRAME_W-1:0];
        col_num   = NUM_W'(rdiv_rem);
        row_num   = NUM_W'(rdiv_q);
    end

    assign out_free = !out_valid_reg || out_ready;

    ssfuv_ctrl #(
        .CNT_W  (CNT_W),
        .FRAC_W (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .ctl      (c)
    );

    // elapsed / frame_length; the quotient stays below the frame count after the wrap.
    ssfuv_serial_div #(
        .N_W (CMP_W),
        .D_W (LEN_W),
        .Q_W (QUO_W)
    ) u_tdiv (
        .clk       (clk),
        .start     (c.wrap_en),
        .step      (c.tdiv_step),
        .dividend  (CMP_W'(wrapped)),
        .divisor   (flen),
        .quotient  (tdiv_q),
        .remainder ()
    );

    // frame / columns gives the row, the remainder the column.
    ssfuv_serial_div #(
        .N_W (FRAME_W),
        .D_W (SIDE_W),
        .Q_W (QUO_W)
    ) u_rdiv (
        .clk       (clk),
        .start     (c.frame_en),
        .step      (c.rdiv_step),
        .dividend  (frame_sat),
        .divisor   (cols),
        .quotient  (rdiv_q),
        .remainder (rdiv_rem)
    );

    ssfuv_edge_lane #(.FRAC_W(FRACTION_BITS)) u_lane_ul (
        .clk      (clk),
        .start    (c.edge_start),
        .step     (c.edge_step),
        .num      (col_num),
        .den      (cols),
        .edge_val (u_left_w)
    );

    ssfuv_edge_lane #(.FRAC_W(FRACTION_BITS)) u_lane_ur (
        .clk      (clk),
        .start    (c.edge_start),
        .step     (c.edge_step),
        .num      (col_num + NUM_W'(1)),
        .den      (cols),
        .edge_val (u_right_w)
    );

    ssfuv_edge_lane #(.FRAC_W(FRACTION_BITS)) u_lane_vt (
        .clk      (clk),
        .start    (c.edge_start),
        .step     (c.edge_step),
        .num      (row_num),
        .den      (rows),
        .edge_val (v_top_w)
    );

    ssfuv_edge_lane #(.FRAC_W(FRACTION_BITS)) u_lane_vb (
        .clk      (clk),
        .start    (c.edge_start),
        .step     (c.edge_step),
        .num      (row_num + NUM_W'(1)),
        .den      (rows),
        .edge_val (v_bottom_w)
    );

    // Payload registers: capture the word, precompute products, hold the frame, load the result.
    always_ff @(posedge clk)
    begin
        if (c.in_ready && in_valid)
        begin
            delta_reg <= time_delta;
        end
        if (c.prep_en)
        begin
            anim_len_reg <= ANIM_W'(count) * ANIM_W'(flen);
            area_reg     <= AREA_W'(cols) * AREA_W'(rows);
        end
        if (c.frame_en)
        begin
            frame_reg <= frame_sat;
        end
        if (c.out_load)
        begin
            frame_out_reg <= frame_reg;
            u_left_reg    <= u_left_w;
            v_top_reg     <= v_top_w;
            u_right_reg   <= u_right_w;
            v_bottom_reg  <= v_bottom_w;
            outside_reg   <= (AREA_W'(frame_reg) >= area_reg);
        end
    end

    // Control state: the time counter and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (c.wrap_en)
            begin
                elapsed_reg <= elapsed_next;
            end
            if (c.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready      = c.in_ready;
    assign out_valid     = out_valid_reg;
    assign frame_number  = frame_out_reg;
    assign u_left        = u_left_reg;
    assign v_top         = v_top_reg;
    assign u_right       = u_right_reg;
    assign v_bottom      = v_bottom_reg;
    assign outside_sheet = outside_reg;

    `SSFUV_ASSERT_IMP(a_wrap_in_range, clk, rst_n, c.wrap_en, CMP_W'(wrapped) < CMP_W'(anim_len_reg))
    `SSFUV_ASSERT_IMP(a_quot_in_count, clk, rst_n, c.frame_en, COUNT_W'(tdiv_q) < count)
    `SSFUV_ASSERT_IMP(a_edges_pinned, clk, rst_n, c.out_load, (u_right_w <= ONE) && (v_bottom_w <= ONE))
    `SSFUV_ASSERT_IMP(a_edges_ordered, clk, rst_n, c.out_load, u_left_w <= u_right_w)

endmodule

`default_nettype wire
